/* src/lbss_pkg.sv */
`default_nettype none

package lbss_pkg;

   localparam int unsigned COUNT_WIDTH_DEFAULT = 16;

   localparam int unsigned LEVEL_WIDTH   = 7;
   localparam int unsigned TICKS_WIDTH   = 16;
   localparam int unsigned REPEAT_WIDTH  = 4;
   localparam int unsigned CSR_IDX_WIDTH = 3;
   localparam int unsigned CSR_DAT_WIDTH = 16;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_SETTLE_TICKS   = 3'd0,
      CSR_ALERT_INTERVAL = 3'd1,
      CSR_ALERT_REPEATS  = 3'd2,
      CSR_RECOVER_LEVEL  = 3'd3,
      CSR_LOW_LEVEL      = 3'd4,
      CSR_CRITICAL_LEVEL = 3'd5,
      CSR_SHUTDOWN_DELAY = 3'd6
   } csr_index_type;

   localparam logic [TICKS_WIDTH-1:0]  SETTLE_TICKS_RST   = 16'd15;
   localparam logic [TICKS_WIDTH-1:0]  ALERT_INTERVAL_RST = 16'd300;
   localparam logic [REPEAT_WIDTH-1:0] ALERT_REPEATS_RST  = 4'd5;
   localparam logic [LEVEL_WIDTH-1:0]  RECOVER_LEVEL_RST  = 7'd25;
   localparam logic [LEVEL_WIDTH-1:0]  LOW_LEVEL_RST      = 7'd15;
   localparam logic [LEVEL_WIDTH-1:0]  CRITICAL_LEVEL_RST = 7'd10;
   localparam logic [TICKS_WIDTH-1:0]  SHUTDOWN_DELAY_RST = 16'd300;

endpackage

`default_nettype wire

/* src/low_battery_shutdown_supervisor.sv */
`default_nettype none
// Channel   Dir   Handshake                 Payload
// req       in    req_valid / req_stall     req_battery_level[6:0]
// rsp       out   rsp_valid / rsp_stall     rsp_alert_pulse, rsp_power_down
// csr       in    csr_wr_en                 csr_index[2:0], csr_wr_data[15:0]
//
// One word per cycle while the output is not stalled: the supervisor counters
// and the output register take their new values in the cycle after acceptance.
// A new word is taken while the output register is empty or being drained.
// Synchronous reset loads the counters from the register reset values, but clears the delay counter.
// A stalled result holds the output register and stalls the input side.

module low_battery_shutdown_supervisor
   import lbss_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [LEVEL_WIDTH-1:0]   req_battery_level,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_alert_pulse,
   output logic                          rsp_power_down,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DAT_WIDTH-1:0] csr_wr_data
);

   logic [TICKS_WIDTH-1:0]  settle_ticks_ff, settle_ticks_in;
   logic [TICKS_WIDTH-1:0]  interval_ticks_ff, interval_ticks_in;
   logic [REPEAT_WIDTH-1:0] repeats_cfg_ff, repeats_cfg_in;
   logic [LEVEL_WIDTH-1:0]  recover_level_ff, recover_level_in;
   logic [LEVEL_WIDTH-1:0]  low_level_ff, low_level_in;
   logic [LEVEL_WIDTH-1:0]  critical_level_ff, critical_level_in;
   logic [TICKS_WIDTH-1:0]  delay_ticks_ff, delay_ticks_in;

   logic [COUNT_WIDTH-1:0]  settle_count_ff, settle_count_in;
   logic [COUNT_WIDTH-1:0]  interval_count_ff, interval_count_in;
   logic [REPEAT_WIDTH-1:0] repeats_left_ff, repeats_left_in;
   logic                    alert_given_ff, alert_given_in;
   logic [COUNT_WIDTH-1:0]  delay_count_ff, delay_count_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_alert_ff, rsp_alert_in;
   logic rsp_pdown_ff, rsp_pdown_in;

   logic                   accept;
   logic [COUNT_WIDTH-1:0] interval_dec;
   logic [COUNT_WIDTH-1:0] delay_load;
   logic                   shutdown_run;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      settle_ticks_in   = settle_ticks_ff;
      interval_ticks_in = interval_ticks_ff;
      repeats_cfg_in    = repeats_cfg_ff;
      recover_level_in  = recover_level_ff;
      low_level_in      = low_level_ff;
      critical_level_in = critical_level_ff;
      delay_ticks_in    = delay_ticks_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SETTLE_TICKS:   settle_ticks_in   = csr_wr_data;
            CSR_ALERT_INTERVAL: interval_ticks_in = csr_wr_data;
            CSR_ALERT_REPEATS:  repeats_cfg_in    = csr_wr_data[REPEAT_WIDTH-1:0];
            CSR_RECOVER_LEVEL:  recover_level_in  = csr_wr_data[LEVEL_WIDTH-1:0];
            CSR_LOW_LEVEL:      low_level_in      = csr_wr_data[LEVEL_WIDTH-1:0];
            CSR_CRITICAL_LEVEL: critical_level_in = csr_wr_data[LEVEL_WIDTH-1:0];
            CSR_SHUTDOWN_DELAY: delay_ticks_in    = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      settle_count_in   = settle_count_ff;
      interval_count_in = interval_count_ff;
      repeats_left_in   = repeats_left_ff;
      alert_given_in    = alert_given_ff;
      delay_count_in    = delay_count_ff;
      rsp_alert_in      = 1'b0;
      rsp_pdown_in      = 1'b0;
      interval_dec      = '0;
      delay_load        = '0;
      shutdown_run      = 1'b0;

      if (settle_count_ff != '0) begin
         settle_count_in = settle_count_ff - 1'b1;
      end else if (req_battery_level > recover_level_ff) begin
         repeats_left_in   = repeats_cfg_ff;
         settle_count_in   = COUNT_WIDTH'(settle_ticks_ff);
         interval_count_in = COUNT_WIDTH'(interval_ticks_ff);
         alert_given_in    = 1'b0;
      end else begin
         interval_dec = (interval_count_ff != '0) ? interval_count_ff - 1'b1 : '0;
         interval_count_in = interval_dec;
         if (repeats_left_ff != '0 && interval_dec == '0) begin
            interval_count_in = COUNT_WIDTH'(interval_ticks_ff);
            repeats_left_in   = repeats_left_ff - 1'b1;
            alert_given_in    = 1'b0;
         end
         if (!alert_given_in) begin
            rsp_alert_in   = 1'b1;
            alert_given_in = 1'b1;
         end
         shutdown_run = !(repeats_left_in != '0 && req_battery_level >= low_level_ff) &&
                        ((interval_count_in == '0 && req_battery_level < low_level_ff) ||
                         req_battery_level < critical_level_ff);
         if (shutdown_run) begin
            delay_load = (delay_count_ff == '0) ? COUNT_WIDTH'(delay_ticks_ff)
                                                : delay_count_ff;
            delay_count_in = (delay_load != '0) ? delay_load - 1'b1 : '0;
            rsp_pdown_in   = (delay_count_in == '0);
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff   <= SETTLE_TICKS_RST;
         interval_ticks_ff <= ALERT_INTERVAL_RST;
         repeats_cfg_ff    <= ALERT_REPEATS_RST;
         recover_level_ff  <= RECOVER_LEVEL_RST;
         low_level_ff      <= LOW_LEVEL_RST;
         critical_level_ff <= CRITICAL_LEVEL_RST;
         delay_ticks_ff    <= SHUTDOWN_DELAY_RST;
         settle_count_ff   <= COUNT_WIDTH'(SETTLE_TICKS_RST);
         interval_count_ff <= COUNT_WIDTH'(ALERT_INTERVAL_RST);
         repeats_left_ff   <= ALERT_REPEATS_RST;
         alert_given_ff    <= 1'b0;
         delay_count_ff    <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         settle_ticks_ff   <= settle_ticks_in;
         interval_ticks_ff <= interval_ticks_in;
         repeats_cfg_ff    <= repeats_cfg_in;
         recover_level_ff  <= recover_level_in;
         low_level_ff      <= low_level_in;
         critical_level_ff <= critical_level_in;
         delay_ticks_ff    <= delay_ticks_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (accept) begin
            settle_count_ff   <= settle_count_in;
            interval_count_ff <= interval_count_in;
            repeats_left_ff   <= repeats_left_in;
            alert_given_ff    <= alert_given_in;
            delay_count_ff    <= delay_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_alert_ff <= rsp_alert_in;
         rsp_pdown_ff <= rsp_pdown_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alert_pulse = rsp_alert_ff;
   assign rsp_power_down  = rsp_pdown_ff;

   a_settle_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && settle_count_ff != '0 |=> rsp_valid_ff && !rsp_alert_ff && !rsp_pdown_ff)
      else $error("output raised while settling");

   a_pdown_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pdown_ff |-> delay_count_ff == '0)
      else $error("power down without expired delay");

   a_alert_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_alert_ff |-> alert_given_ff)
      else $error("alert issued but flag clear");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty output register");

endmodule

`default_nettype wire
